@@ rtl/tvp_pkg.sv @@
// Package for the varint TLV frame parser.
// Holds the parse phases, event codes, the event record, register indexes and the varint helper.
// No dependencies.
package tvp_pkg;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_WORD      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TERMINATOR_BYTE = CSR_INDEX_W'(1);

   localparam logic [15:0] MAGIC_WORD_RESET      = 16'hABCF;
   localparam logic [7:0]  TERMINATOR_BYTE_RESET = 8'h2C;

   localparam int unsigned VARINT_GROUPS  = 10;
   localparam logic [3:0]  VARINT_CNT_MAX = 4'd15;

   typedef enum logic [2:0] {
      PH_MAGIC0,
      PH_MAGIC1,
      PH_FLEN,
      PH_TID,
      PH_TLEN,
      PH_PAYLOAD,
      PH_TERM
   } phase_type;

   typedef enum logic [2:0] {
      EV_HEADER,
      EV_BYTE,
      EV_OK,
      EV_NOTERM,
      EV_BADMAGIC
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [31:0]    token_id;
      logic [31:0]    payload_length;
      logic [31:0]    store_offset;
      logic [7:0]     payload_data;
      logic           length_overrun;
   } event_type;

   // Places the seven data bits of a varint byte at its group position.
   function automatic logic [63:0] varint_bits(input logic [7:0] data, input logic [3:0] cnt);
      logic [63:0] bits;
      bits = '0;
      for (int k = 0; k < VARINT_GROUPS; k++) begin
         if (cnt == 4'(k)) begin
            bits = {57'd0, data[6:0]} << (7 * k);
         end
      end
      return bits;
   endfunction

endpackage

@@ rtl/tvp_in_stage.sv @@
// Input register of the varint TLV frame parser.
// Holds one accepted byte until the parse core consumes it; uses tvp_pkg.
module tvp_in_stage
   import tvp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       fire,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   assign req_ready = !valid_ff || fire;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         byte_in  = req_data_byte;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

@@ rtl/tvp_parse_core.sv @@
// Parse core of the varint TLV frame parser: frame state, configuration registers
// and the combinational decode of one byte into at most one event. Uses tvp_pkg.
module tvp_parse_core
   import tvp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   fire,
   input  logic [7:0]             in_byte,
   output logic                   ev_valid,
   output event_type              ev
);

   logic [15:0] magic_ff;
   logic [7:0]  term_ff;

   phase_type   phase_ff, phase_in;
   logic [7:0]  first_ff, first_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] fbl_ff, fbl_in;
   logic        ovr_ff, ovr_in;
   logic [31:0] tid_ff, tid_in;
   logic [31:0] pl_ff, pl_in;
   logic [31:0] off_ff, off_in;

   logic [63:0] acc_take;
   logic [3:0]  cnt_take;
   logic        varint_last;
   logic [63:0] fbl_dec;
   logic        fbl_empty;
   logic        fbl_dec_zero;
   logic [31:0] pl_len;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_WORD_RESET;
         term_ff  <= TERMINATOR_BYTE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAGIC_WORD: begin
               magic_ff <= csr_data[15:0];
            end
            CSR_TERMINATOR_BYTE: begin
               term_ff <= csr_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC0;
         first_ff <= '0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         fbl_ff   <= '0;
         ovr_ff   <= 1'b0;
         tid_ff   <= '0;
         pl_ff    <= '0;
         off_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         fbl_ff   <= fbl_in;
         ovr_ff   <= ovr_in;
         tid_ff   <= tid_in;
         pl_ff    <= pl_in;
         off_ff   <= off_in;
      end
   end

   always_comb begin
      acc_take     = acc_ff | varint_bits(in_byte, cnt_ff);
      cnt_take     = (cnt_ff == VARINT_CNT_MAX) ? cnt_ff : cnt_ff + 4'd1;
      varint_last  = !in_byte[7];
      fbl_empty    = (fbl_ff == 64'd0);
      fbl_dec      = fbl_empty ? 64'd0 : fbl_ff - 64'd1;
      fbl_dec_zero = (fbl_ff[63:1] == 63'd0);
      pl_len       = (acc_take[63:32] != 32'd0) ? 32'hFFFF_FFFF : acc_take[31:0];

      phase_in = phase_ff;
      first_in = first_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      fbl_in   = fbl_ff;
      ovr_in   = ovr_ff;
      tid_in   = tid_ff;
      pl_in    = pl_ff;
      off_in   = off_ff;
      ev       = '0;
      ev_valid = 1'b0;

      case (phase_ff)
         PH_MAGIC1: begin
            if ({first_ff, in_byte} != magic_ff) begin
               ev.kind  = EV_BADMAGIC;
               ev_valid = 1'b1;
               phase_in = PH_MAGIC0;
            end else begin
               acc_in   = '0;
               cnt_in   = '0;
               fbl_in   = '0;
               ovr_in   = 1'b0;
               off_in   = '0;
               phase_in = PH_FLEN;
            end
         end
         PH_FLEN: begin
            acc_in = acc_take;
            cnt_in = cnt_take;
            if (varint_last) begin
               fbl_in   = acc_take;
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = (acc_take == 64'd0) ? PH_TERM : PH_TID;
            end
         end
         PH_TID: begin
            fbl_in = fbl_dec;
            ovr_in = ovr_ff | fbl_empty;
            acc_in = acc_take;
            cnt_in = cnt_take;
            if (varint_last) begin
               tid_in   = acc_take[31:0];
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = PH_TLEN;
            end
         end
         PH_TLEN: begin
            fbl_in = fbl_dec;
            ovr_in = ovr_ff | fbl_empty;
            acc_in = acc_take;
            cnt_in = cnt_take;
            if (varint_last) begin
               pl_in             = pl_len;
               ev.kind           = EV_HEADER;
               ev.token_id       = tid_ff;
               ev.payload_length = pl_len;
               ev.store_offset   = off_ff;
               ev_valid          = 1'b1;
               if (pl_len == 32'd0) begin
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = fbl_dec_zero ? PH_TERM : PH_TID;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            fbl_in          = fbl_dec;
            ovr_in          = ovr_ff | fbl_empty;
            ev.kind         = EV_BYTE;
            ev.store_offset = off_ff;
            ev.payload_data = in_byte;
            ev_valid        = 1'b1;
            off_in          = off_ff + 32'd1;
            pl_in           = pl_ff - 32'd1;
            if (pl_ff == 32'd1) begin
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = fbl_dec_zero ? PH_TERM : PH_TID;
            end
         end
         PH_TERM: begin
            ev.kind           = (in_byte == term_ff) ? EV_OK : EV_NOTERM;
            ev.length_overrun = ovr_ff;
            ev_valid          = 1'b1;
            phase_in          = PH_MAGIC0;
         end
         default: begin
            first_in = in_byte;
            phase_in = PH_MAGIC1;
         end
      endcase
   end

   a_badmagic_restart: assert property (@(posedge clock) disable iff (reset)
      fire && ev_valid && ev.kind == EV_BADMAGIC |=> phase_ff == PH_MAGIC0)
      else $error("bad magic did not return to the magic search");

   a_frame_end_restart: assert property (@(posedge clock) disable iff (reset)
      fire && ev_valid && (ev.kind == EV_OK || ev.kind == EV_NOTERM)
      |=> phase_ff == PH_MAGIC0)
      else $error("frame end did not return to the magic search");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> pl_ff != 32'd0)
      else $error("payload phase entered with no bytes left");

   a_offset_step: assert property (@(posedge clock) disable iff (reset)
      fire && ev.kind == EV_BYTE && ev_valid |=> off_ff == $past(off_ff) + 32'd1)
      else $error("store offset did not advance on a payload byte");

endmodule

@@ rtl/tvp_out_stage.sv @@
// Result register of the varint TLV frame parser.
// Holds one event word until the consumer takes it; uses tvp_pkg.
module tvp_out_stage
   import tvp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      fire,
   input  logic      ev_valid,
   input  event_type ev,
   output logic      load_ok,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output event_type rsp_ev
);

   logic      valid_ff;
   logic      valid_in;
   event_type ev_ff;
   event_type ev_in;

   assign load_ok = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      ev_in    = ev_ff;
      if (fire) begin
         valid_in = ev_valid;
         ev_in    = ev;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ev_ff <= ev_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_ev    = ev_ff;

endmodule

@@ rtl/varint_tlv_frame_parser_unit.sv @@
// Top level of the varint TLV frame parser.
// Connects tvp_in_stage, tvp_parse_core and tvp_out_stage; uses tvp_pkg.
//
// The parser takes one frame byte per cycle unless the event consumer stalls, and gives at
// most one event per byte: the byte is held in the input register and its event in the
// result register. The sustained rate of one byte per clock is set by the parse core,
// which decodes a byte combinationally and updates the whole frame state as it is consumed.
// Configuration writes are taken at any time but are meant for an idle parser.
module varint_tlv_frame_parser_unit
   import tvp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_event_kind,
   output logic [31:0]            rsp_token_id,
   output logic [31:0]            rsp_payload_length,
   output logic [31:0]            rsp_store_offset,
   output logic [7:0]             rsp_payload_data,
   output logic                   rsp_length_overrun
);

   logic      in_valid;
   logic [7:0] in_byte;
   logic      load_ok;
   logic      fire;
   logic      ev_valid;
   event_type ev;
   event_type rsp_ev;

   assign fire = in_valid && load_ok;

   tvp_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .fire          (fire),
      .in_valid      (in_valid),
      .in_byte       (in_byte)
   );

   tvp_parse_core u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .fire      (fire),
      .in_byte   (in_byte),
      .ev_valid  (ev_valid),
      .ev        (ev)
   );

   tvp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .ev_valid  (ev_valid),
      .ev        (ev),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_ev    (rsp_ev)
   );

   assign rsp_event_kind     = rsp_ev.kind;
   assign rsp_token_id       = rsp_ev.token_id;
   assign rsp_payload_length = rsp_ev.payload_length;
   assign rsp_store_offset   = rsp_ev.store_offset;
   assign rsp_payload_data   = rsp_ev.payload_data;
   assign rsp_length_overrun = rsp_ev.length_overrun;

endmodule

@@ test/tvp_frame_checker.sv @@
// Scoreboard for the varint TLV frame parser: tracks register writes, predicts the
// event, if any, for each accepted frame byte and checks it against every emitted event.
// Depends on tvp_pkg for phases, event codes, the event record and register indexes.
module tvp_frame_checker
   import tvp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [2:0]             rsp_event_kind,
   input  logic [31:0]            rsp_token_id,
   input  logic [31:0]            rsp_payload_length,
   input  logic [31:0]            rsp_store_offset,
   input  logic [7:0]             rsp_payload_data,
   input  logic                   rsp_length_overrun,
   output int                     mismatch_count,
   output int                     open_events
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] magic_cfg;
   logic [7:0]  term_cfg;
   phase_type   phase;
   logic [7:0]  magic_hi;
   logic [63:0] group_acc;
   logic [3:0]  group_cnt;
   logic [63:0] frame_left;
   logic        overrun_seen;
   logic [31:0] token_id_now;
   logic [31:0] payload_left;
   logic [31:0] store_pos;
   event_type   awaited_events[$];

   function automatic void clear_groups();
      group_acc = '0;
      group_cnt = '0;
   endfunction

   // Returns 1 on the closing byte of a varint.
   function automatic bit take_group(input logic [7:0] b);
      if (group_cnt < 4'd10) begin
         group_acc |= 64'(b[6:0]) << (7 * group_cnt);
      end
      if (group_cnt != 4'd15) begin
         group_cnt++;
      end
      return !b[7];
   endfunction

   function automatic void count_frame_byte();
      if (frame_left == '0) begin
         overrun_seen = 1'b1;
      end else begin
         frame_left--;
      end
   endfunction

   function automatic void end_token();
      clear_groups();
      phase = (frame_left == '0) ? PH_TERM : PH_TID;
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      event_type ev;
      ev = '0;
      case (phase)
         PH_MAGIC1: begin
            if ({magic_hi, b} != magic_cfg) begin
               ev.kind = EV_BADMAGIC;
               awaited_events.push_back(ev);
               phase = PH_MAGIC0;
            end else begin
               clear_groups();
               frame_left = '0;
               overrun_seen = 1'b0;
               store_pos = '0;
               phase = PH_FLEN;
            end
         end
         PH_FLEN: begin
            if (take_group(b)) begin
               frame_left = group_acc;
               end_token();
            end
         end
         PH_TID: begin
            count_frame_byte();
            if (take_group(b)) begin
               token_id_now = group_acc[31:0];
               clear_groups();
               phase = PH_TLEN;
            end
         end
         PH_TLEN: begin
            count_frame_byte();
            if (take_group(b)) begin
               payload_left = (group_acc[63:32] != '0) ? '1 : group_acc[31:0];
               ev.kind = EV_HEADER;
               ev.token_id = token_id_now;
               ev.payload_length = payload_left;
               ev.store_offset = store_pos;
               awaited_events.push_back(ev);
               if (payload_left == '0) begin
                  end_token();
               end else begin
                  phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            count_frame_byte();
            ev.kind = EV_BYTE;
            ev.store_offset = store_pos;
            ev.payload_data = b;
            awaited_events.push_back(ev);
            store_pos++;
            payload_left--;
            if (payload_left == '0) begin
               end_token();
            end
         end
         PH_TERM: begin
            ev.kind = (b == term_cfg) ? EV_OK : EV_NOTERM;
            ev.length_overrun = overrun_seen;
            awaited_events.push_back(ev);
            phase = PH_MAGIC0;
         end
         default: begin
            magic_hi = b;
            phase = PH_MAGIC1;
         end
      endcase
   endfunction

   function automatic void flag_mismatch(input string note, input event_type want,
                                         input event_type seen);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, note);
         $display("   expected kind %0d id %h len %h offset %h data %h overrun %b",
                  want.kind, want.token_id, want.payload_length, want.store_offset,
                  want.payload_data, want.length_overrun);
         $display("   actual   kind %0d id %h len %h offset %h data %h overrun %b",
                  seen.kind, seen.token_id, seen.payload_length, seen.store_offset,
                  seen.payload_data, seen.length_overrun);
      end
   endfunction

   always @(posedge clock) begin
      event_type seen;
      event_type want;
      if (reset) begin
         magic_cfg = MAGIC_WORD_RESET;
         term_cfg = TERMINATOR_BYTE_RESET;
         phase = PH_MAGIC0;
         magic_hi = '0;
         clear_groups();
         frame_left = '0;
         overrun_seen = 1'b0;
         token_id_now = '0;
         payload_left = '0;
         store_pos = '0;
         awaited_events.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_event_kind, rsp_token_id, rsp_payload_length, rsp_store_offset,
                    rsp_payload_data, rsp_length_overrun};
            if (awaited_events.size() == 0) begin
               flag_mismatch("event word with none outstanding", '0, seen);
            end else begin
               want = awaited_events.pop_front();
               if (seen !== want) begin
                  flag_mismatch("event word differs from prediction", want, seen);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAGIC_WORD: begin
                  magic_cfg = csr_data[15:0];
               end
               CSR_TERMINATOR_BYTE: begin
                  term_cfg = csr_data[7:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            parse_byte(req_data_byte);
         end
      end
      open_events = awaited_events.size();
   end

endmodule

@@ test/tb_varint_tlv_frame_parser_unit.sv @@
// Top testbench for varint_tlv_frame_parser_unit: drives frames, noise and register
// settings with random idling, and reports the verdict from tvp_frame_checker.
// Depends on tvp_pkg, tvp_frame_checker and the parser RTL.
module tb_varint_tlv_frame_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import tvp_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 205;
   localparam int SETTLE       = 8;
   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_BYTES   = 60;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_event_kind;
   logic [31:0]            rsp_token_id;
   logic [31:0]            rsp_payload_length;
   logic [31:0]            rsp_store_offset;
   logic [7:0]             rsp_payload_data;
   logic                   rsp_length_overrun;
   int                     mismatch_count;
   int                     open_events;
   int                     cycle_count = 0;

   logic [7:0]  frame_bytes[$];
   logic [15:0] magic_now;
   logic [7:0]  term_now;
   int          sent_count = 0;
   bit          send_brisk = 1'b0;

   varint_tlv_frame_parser_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_token_id       (rsp_token_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_store_offset   (rsp_store_offset),
      .rsp_payload_data   (rsp_payload_data),
      .rsp_length_overrun (rsp_length_overrun)
   );

   tvp_frame_checker frame_check (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_token_id       (rsp_token_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_store_offset   (rsp_store_offset),
      .rsp_payload_data   (rsp_payload_data),
      .rsp_length_overrun (rsp_length_overrun),
      .mismatch_count     (mismatch_count),
      .open_events        (open_events)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Event drain: random stalls per word, quiet stretches, and one long hold-off.
   initial begin : drain
      int gap;
      int taken;
      bit brisk;
      taken = 0;
      brisk = 1'b0;
      @(negedge reset);
      forever begin
         if (taken % 64 == 0) begin
            brisk = ($urandom_range(0, 3) == 0);
         end
         gap = brisk ? 0 : $urandom_range(0, 7);
         if (taken == HOLD_AT) begin
            gap = HOLD_CYCLES;
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (sent_count % 64 == 0) begin
         send_brisk = ($urandom_range(0, 3) == 0);
      end
      gap = send_brisk ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic flush_bytes();
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i]);
      end
      frame_bytes.delete();
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_events != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input logic [15:0] magic, input logic [7:0] term);
      write_csr(CSR_MAGIC_WORD, magic);
      write_csr(CSR_TERMINATOR_BYTE, {8'($urandom), term});
      write_csr(CSR_INDEX_W'($urandom_range(2, 15)), CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      magic_now = magic;
      term_now = term;
   endtask

   // Appends a varint, padded with extra continuation bytes past its minimal length.
   function automatic void add_varint(input logic [63:0] value, input int pad);
      int groups;
      int total;
      logic [6:0] g;
      groups = 1;
      while (groups < 10 && (value >> (7 * groups)) != 0) begin
         groups++;
      end
      total = groups + pad;
      for (int i = 0; i < total; i++) begin
         g = (i < 10) ? 7'(value >> (7 * i)) : 7'($urandom);
         frame_bytes.push_back({i != total - 1, g});
      end
   endfunction

   function automatic int pad_draw();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
   endfunction

   function automatic logic [63:0] id_draw();
      case ($urandom_range(0, 4))
         0: begin
            return 64'd0;
         end
         1: begin
            return 64'h0000_0000_FFFF_FFFF;
         end
         2: begin
            return {$urandom, $urandom};
         end
         3: begin
            return 64'($urandom_range(0, 127));
         end
         default: begin
            return 64'($urandom);
         end
      endcase
   endfunction

   // A declared length short of the token bytes runs out inside the last token.
   task automatic send_frame(input int tokens, input bit overrun, input bit bad_end);
      logic [7:0]  body[$];
      logic [63:0] declared;
      int          tok_start;
      int          tok_bytes;
      int          plen;
      frame_bytes.delete();
      tok_bytes = 0;
      for (int t = 0; t < tokens; t++) begin
         tok_start = frame_bytes.size();
         plen = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
         add_varint(id_draw(), pad_draw());
         add_varint(64'(plen), pad_draw());
         repeat (plen) frame_bytes.push_back(8'($urandom));
         tok_bytes = frame_bytes.size() - tok_start;
      end
      declared = 64'(frame_bytes.size());
      if (overrun && tokens != 0) begin
         declared -= 64'($urandom_range(1, tok_bytes - 1));
      end
      body = frame_bytes;
      frame_bytes.delete();
      frame_bytes.push_back(magic_now[15:8]);
      frame_bytes.push_back(magic_now[7:0]);
      add_varint(declared, pad_draw());
      foreach (body[i]) begin
         frame_bytes.push_back(body[i]);
      end
      frame_bytes.push_back(bad_end ? (term_now ^ 8'($urandom_range(1, 255))) : term_now);
      flush_bytes();
   endtask

   task automatic send_noise(input int pairs);
      logic [15:0] pair;
      for (int p = 0; p < pairs; p++) begin
         do pair = 16'($urandom); while (pair == magic_now);
         if ($urandom_range(0, 3) == 0) begin
            pair = magic_now ^ (16'd1 << $urandom_range(0, 15));
         end
         send_byte(pair[15:8]);
         send_byte(pair[7:0]);
      end
   endtask

   initial begin : stimulus
      logic [7:0] opening[25];
      int         phase_end;
      opening = '{8'h00, 8'hFF,
                  MAGIC_WORD_RESET[15:8], MAGIC_WORD_RESET[7:0], 8'h00, TERMINATOR_BYTE_RESET,
                  MAGIC_WORD_RESET[15:8], MAGIC_WORD_RESET[7:0], 8'h86, 8'h80, 8'h00,
                  8'h7F, 8'h00, 8'h05, 8'h02, 8'h00, 8'hFF, TERMINATOR_BYTE_RESET,
                  MAGIC_WORD_RESET[15:8], MAGIC_WORD_RESET[7:0], 8'h01, 8'h03, 8'h01,
                  8'hAA, 8'hFF};
      magic_now = MAGIC_WORD_RESET;
      term_now = TERMINATOR_BYTE_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) begin
         frame_bytes.push_back(opening[i]);
      end
      flush_bytes();
      wait_quiet();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               apply_settings(16'h0000, 8'h00);
            end
            1: begin
               apply_settings(16'hFFFF, 8'hFF);
            end
            default: begin
               apply_settings(16'($urandom), 8'($urandom));
            end
         endcase
         phase_end = sent_count + PHASE_ITEMS;
         while (sent_count < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               send_noise($urandom_range(1, 3));
            end else begin
               send_frame($urandom_range(0, 4), $urandom_range(0, 5) == 0,
                          $urandom_range(0, 5) == 0);
            end
         end
         wait_quiet();
      end

      // A payload length beyond 32 bits saturates to 32'hFFFF_FFFF and keeps the parser in the payload
      // for the rest of the run, so this frame closes the run.
      frame_bytes.push_back(magic_now[15:8]);
      frame_bytes.push_back(magic_now[7:0]);
      add_varint('1, 0);
      add_varint({$urandom, $urandom}, 0);
      add_varint({$urandom, $urandom} | 64'h0000_0001_0000_0000, 0);
      repeat (TAIL_BYTES) frame_bytes.push_back(8'($urandom));
      flush_bytes();
      wait_quiet();

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
